// ===== sv/ccsb_pkg.sv =====
// Package for the clipped colour-key sprite blitter: widths, register indexes,
// request kinds and the structs passed between the pipeline stages.
// Depends on nothing; every other file imports it.
`timescale 1ns / 1ps

package ccsb_pkg;

    // Register indexes on the configuration port
    localparam int unsigned CfgIndexW = 3;
    localparam logic [CfgIndexW-1:0] REG_VIEW_WIDTH    = 3'd0;
    localparam logic [CfgIndexW-1:0] REG_VIEW_HEIGHT   = 3'd1;
    localparam logic [CfgIndexW-1:0] REG_LINE_PITCH    = 3'd2;
    localparam logic [CfgIndexW-1:0] REG_SCROLL_X      = 3'd3;
    localparam logic [CfgIndexW-1:0] REG_SCROLL_Y      = 3'd4;
    localparam logic [CfgIndexW-1:0] REG_DEST_BASE     = 3'd5;
    localparam logic [CfgIndexW-1:0] REG_HONOUR_HIDDEN = 3'd6;

    localparam int unsigned CfgDataW = 32;

    // Request kinds carried on s_tuser
    localparam logic REQ_HEADER = 1'b0;
    localparam logic REQ_PIXEL  = 1'b1;

    localparam int unsigned CoordW = 16;  // world coordinates
    localparam int unsigned DimW   = 12;  // frame and view sizes
    localparam int unsigned PitchW = 16;
    localparam int unsigned AddrW  = 32;
    localparam int unsigned PixW   = 8;

    localparam int unsigned InDataW  = 72;  // 65 field bits padded to bytes
    localparam int unsigned OutDataW = 40;

    // Reset values of the registers
    localparam logic [DimW-1:0]   VIEW_WIDTH_RST  = 12'd320;
    localparam logic [DimW-1:0]   VIEW_HEIGHT_RST = 12'd200;
    localparam logic [PitchW-1:0] LINE_PITCH_RST  = 16'd320;

    typedef struct packed {
        logic [DimW-1:0]          view_width;
        logic [DimW-1:0]          view_height;
        logic [PitchW-1:0]        line_pitch;
        logic signed [CoordW-1:0] scroll_x;
        logic signed [CoordW-1:0] scroll_y;
        logic [AddrW-1:0]         dest_base;
        logic                     honour_hidden;
    } cfg_t;

    // One input transaction, unpacked
    typedef struct packed {
        logic                     req_type;
        logic signed [CoordW-1:0] sprite_x;
        logic signed [CoordW-1:0] sprite_y;
        logic [DimW-1:0]          frame_width;
        logic [DimW-1:0]          frame_height;
        logic                     hidden;
        logic [PixW-1:0]          pixel;
    } req_t;

    // A visible, opaque pixel in view coordinates
    typedef struct packed {
        logic [DimW-1:0] px;
        logic [DimW-1:0] py;
        logic [PixW-1:0] value;
    } hit_t;

endpackage

// ===== sv/ccsb_track.sv =====
// Sprite tracker and clip stage: holds the current sprite's origin, size and
// raster position, and registers each visible opaque pixel. Uses ccsb_pkg.
`timescale 1ns / 1ps

module ccsb_track (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          load,       // input transaction accepted
    input  logic          drain,      // stage register moves on
    input  ccsb_pkg::req_t req,
    input  ccsb_pkg::cfg_t cfg,
    output logic          hit_valid,
    output ccsb_pkg::hit_t hit
);
    import ccsb_pkg::*;

    logic signed [CoordW:0] origin_x_reg, origin_x_next;
    logic signed [CoordW:0] origin_y_reg, origin_y_next;
    logic [DimW-1:0] cur_width_reg, cur_width_next;
    logic [DimW-1:0] cur_height_reg, cur_height_next;
    logic [DimW-1:0] column_reg, column_next;
    logic [DimW-1:0] row_reg, row_next;
    logic            suppressed_reg, suppressed_next;
    logic            hit_valid_reg, hit_valid_next;
    hit_t            hit_reg, hit_next;

    logic signed [CoordW+1:0] px;
    logic signed [CoordW+1:0] py;
    logic [DimW:0]            column_inc;
    logic [DimW:0]            row_inc;
    logic                     visible;

    always_comb begin
        px = {origin_x_reg[CoordW], origin_x_reg} + $signed({6'b0, column_reg});
        py = {origin_y_reg[CoordW], origin_y_reg} + $signed({6'b0, row_reg});
        visible = (req.pixel != '0) && !px[CoordW+1] && !py[CoordW+1]
                  && (px[CoordW:0] < {5'b0, cfg.view_width})
                  && (py[CoordW:0] < {5'b0, cfg.view_height});
        column_inc = {1'b0, column_reg} + 13'd1;
        row_inc    = {1'b0, row_reg} + 13'd1;
    end

    always_comb begin
        origin_x_next   = origin_x_reg;
        origin_y_next   = origin_y_reg;
        cur_width_next  = cur_width_reg;
        cur_height_next = cur_height_reg;
        column_next     = column_reg;
        row_next        = row_reg;
        suppressed_next = suppressed_reg;
        hit_valid_next  = drain ? 1'b0 : hit_valid_reg;
        hit_next        = hit_reg;
        if (load) begin
            hit_valid_next = 1'b0;
            if (req.req_type == REQ_HEADER) begin
                origin_x_next   = {req.sprite_x[CoordW-1], req.sprite_x}
                                  - {cfg.scroll_x[CoordW-1], cfg.scroll_x};
                origin_y_next   = {req.sprite_y[CoordW-1], req.sprite_y}
                                  - {cfg.scroll_y[CoordW-1], cfg.scroll_y};
                cur_width_next  = req.frame_width;
                cur_height_next = req.frame_height;
                column_next     = '0;
                row_next        = '0;
                suppressed_next = (req.frame_width == '0) || (req.frame_height == '0)
                                  || (req.hidden && cfg.honour_hidden);
            end else if (!suppressed_reg) begin
                hit_valid_next = visible;
                hit_next.px    = px[DimW-1:0];
                hit_next.py    = py[DimW-1:0];
                hit_next.value = req.pixel;
                // advance raster position, close the frame after its last pixel
                if (column_inc >= {1'b0, cur_width_reg}) begin
                    column_next = '0;
                    if (row_inc >= {1'b0, cur_height_reg}) begin
                        row_next        = '0;
                        suppressed_next = 1'b1;
                    end else begin
                        row_next = row_inc[DimW-1:0];
                    end
                end else begin
                    column_next = column_inc[DimW-1:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            origin_x_reg   <= '0;
            origin_y_reg   <= '0;
            cur_width_reg  <= '0;
            cur_height_reg <= '0;
            column_reg     <= '0;
            row_reg        <= '0;
            suppressed_reg <= 1'b1;
            hit_valid_reg  <= 1'b0;
        end else begin
            origin_x_reg   <= origin_x_next;
            origin_y_reg   <= origin_y_next;
            cur_width_reg  <= cur_width_next;
            cur_height_reg <= cur_height_next;
            column_reg     <= column_next;
            row_reg        <= row_next;
            suppressed_reg <= suppressed_next;
            hit_valid_reg  <= hit_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        hit_reg <= hit_next;
    end

    assign hit_valid = hit_valid_reg;
    assign hit       = hit_reg;

endmodule

// ===== sv/ccsb_addr.sv =====
// Address stage: forms base + y*pitch + x for a visible pixel and holds the
// write in the output register until it is taken. Uses ccsb_pkg.
`timescale 1ns / 1ps

module ccsb_addr (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          advance,
    input  logic                          hit_valid,
    input  ccsb_pkg::hit_t                hit,
    input  ccsb_pkg::cfg_t                cfg,
    output logic                          out_valid,
    output logic [ccsb_pkg::AddrW-1:0]    out_address,
    output logic [ccsb_pkg::PixW-1:0]     out_value
);
    import ccsb_pkg::*;

    localparam int unsigned ProdW = DimW + PitchW;

    logic [ProdW-1:0] row_offset;
    logic             valid_reg, valid_next;
    logic [AddrW-1:0] address_reg, address_next;
    logic [PixW-1:0]  value_reg, value_next;

    always_comb begin
        row_offset   = ProdW'(hit.py) * ProdW'(cfg.line_pitch);
        valid_next   = valid_reg;
        address_next = address_reg;
        value_next   = value_reg;
        if (advance) begin
            valid_next   = hit_valid;
            address_next = cfg.dest_base + AddrW'(row_offset) + AddrW'(hit.px);
            value_next   = hit.value;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        address_reg <= address_next;
        value_reg   <= value_next;
    end

    assign out_valid   = valid_reg;
    assign out_address = address_reg;
    assign out_value   = value_reg;

endmodule

// ===== sv/clipped_colorkey_sprite_blit_core.sv =====
// Top level of the clipped colour-key sprite blitter: stream ports, the
// configuration registers and the two pipeline stages. Uses ccsb_pkg,
// ccsb_track and ccsb_addr.
//
// A header transaction (tuser 0) opens a sprite; the pixel transactions that
// follow (tuser 1) arrive in raster order, one frame row after another. Each
// opaque pixel whose view position lies inside view_width x view_height turns
// into one write transaction on the m_ side carrying the byte address
// dest_base + y*line_pitch + x and the pixel value. Transparent pixels,
// clipped pixels, pixels of hidden sprites (when honour_hidden is set) and
// pixels beyond the end of the frame give nothing. One transaction is taken
// every clock unless a stalled output register holds a full clip stage. The
// clip runs on the incoming pixel and is registered at the accepting edge;
// the address is then formed from that register with a single 12 x 16 bit
// multiply and registered in the output register that drives m_tvalid. Scroll
// and honour_hidden are sampled by each header; the other registers act on
// every pixel. Write the registers only while no transaction is in flight.
`timescale 1ns / 1ps

module clipped_colorkey_sprite_blit_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration write port
    input  logic                              cfg_we,
    input  logic [ccsb_pkg::CfgIndexW-1:0]    cfg_index,
    input  logic [ccsb_pkg::CfgDataW-1:0]     cfg_data,
    // request stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [15:0] sprite_x, [31:16] sprite_y, [43:32] frame_width,
    // [55:44] frame_height, [56] hidden, [64:57] pixel, [71:65] zero
    input  logic [ccsb_pkg::InDataW-1:0]      s_tdata,
    // [0] req_type
    input  logic                              s_tuser,
    // write stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [31:0] write_address, [39:32] write_value
    output logic [ccsb_pkg::OutDataW-1:0]     m_tdata
);
    import ccsb_pkg::*;

    cfg_t cfg_reg, cfg_next;
    req_t req;
    hit_t hit;
    logic hit_valid;
    logic advance;
    logic load;
    logic             out_valid;
    logic [AddrW-1:0] out_address;
    logic [PixW-1:0]  out_value;

    // Register file: take a write whenever the enable is high
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                REG_VIEW_WIDTH:    cfg_next.view_width    = cfg_data[DimW-1:0];
                REG_VIEW_HEIGHT:   cfg_next.view_height   = cfg_data[DimW-1:0];
                REG_LINE_PITCH:    cfg_next.line_pitch    = cfg_data[PitchW-1:0];
                REG_SCROLL_X:      cfg_next.scroll_x      = cfg_data[CoordW-1:0];
                REG_SCROLL_Y:      cfg_next.scroll_y      = cfg_data[CoordW-1:0];
                REG_DEST_BASE:     cfg_next.dest_base     = cfg_data[AddrW-1:0];
                REG_HONOUR_HIDDEN: cfg_next.honour_hidden = cfg_data[0];
                default:           cfg_next = cfg_reg;  // unmapped index: drop
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.view_width    <= VIEW_WIDTH_RST;
            cfg_reg.view_height   <= VIEW_HEIGHT_RST;
            cfg_reg.line_pitch    <= LINE_PITCH_RST;
            cfg_reg.scroll_x      <= '0;
            cfg_reg.scroll_y      <= '0;
            cfg_reg.dest_base     <= '0;
            cfg_reg.honour_hidden <= 1'b1;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Unpack the request transaction
    assign req.req_type     = s_tuser;
    assign req.sprite_x     = s_tdata[15:0];
    assign req.sprite_y     = s_tdata[31:16];
    assign req.frame_width  = s_tdata[43:32];
    assign req.frame_height = s_tdata[55:44];
    assign req.hidden       = s_tdata[56];
    assign req.pixel        = s_tdata[64:57];

    // Advance the output register when it is empty or being taken; hold the
    // clip stage otherwise. A new request enters whenever the clip stage
    // is empty or moving on.
    assign advance  = !out_valid || m_tready;
    assign s_tready = !hit_valid || advance;
    assign load     = s_tvalid && s_tready;

    ccsb_track u_track (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (load),
        .drain     (advance),
        .req       (req),
        .cfg       (cfg_reg),
        .hit_valid (hit_valid),
        .hit       (hit)
    );

    ccsb_addr u_addr (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .advance     (advance),
        .hit_valid   (hit_valid),
        .hit         (hit),
        .cfg         (cfg_reg),
        .out_valid   (out_valid),
        .out_address (out_address),
        .out_value   (out_value)
    );

    assign m_tvalid = out_valid;
    assign m_tdata  = {out_value, out_address};

endmodule

// ===== verif/clipped_colorkey_sprite_blit_core_tb.sv =====
// Self-checking testbench for clipped_colorkey_sprite_blit_core: directed rows, then
// randomised sprite streams under varied register settings, checked against a predictor.
// Depends on ccsb_pkg and the blitter core; reads no files.
`timescale 1ns / 1ps

module clipped_colorkey_sprite_blit_core_tb;
    import ccsb_pkg::*;

    // Run shape
    localparam int NumPhases   = 8;     // register settings in the random part
    localparam int PhaseItems  = 115;   // input transactions per setting
    localparam int MaxIdle     = 18;    // longest gap or stall drawn per transaction
    localparam int DrainLimit  = 2000;  // cycles allowed for outstanding writes to land
    localparam int SettleCyc   = 8;     // pipeline is two deep; give it a margin
    localparam int MaxPrinted  = 40;

    // How a directed row is checked
    typedef enum logic [1:0] {
        EXP_MODEL,  // predictor decides
        EXP_WRITE,  // the typed write is expected
        EXP_NONE    // no write may follow
    } exp_kind_t;

    typedef enum logic {
        ROW_ITEM,
        ROW_REG
    } row_kind_t;

    typedef struct packed {
        logic [AddrW-1:0] addr;
        logic [PixW-1:0]  value;
    } blit_write_t;

    typedef struct packed {
        row_kind_t            kind;
        exp_kind_t            ek;
        req_t                 req;
        blit_write_t          want;
        logic [CfgIndexW-1:0] reg_idx;
        logic [CfgDataW-1:0]  reg_val;
    } dir_row_t;

    // DUT ports; every input holds a known value from time zero
    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CfgIndexW-1:0] cfg_index = '0;
    logic [CfgDataW-1:0]  cfg_data  = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [InDataW-1:0]   s_tdata   = '0;
    logic                 s_tuser   = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [OutDataW-1:0]  m_tdata;

    clipped_colorkey_sprite_blit_core DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // Predictor copy of the registers and the sprite walker
    cfg_t               view_cfg;
    logic signed [16:0] spr_org_x;
    logic signed [16:0] spr_org_y;
    logic [DimW-1:0]    spr_w;
    logic [DimW-1:0]    spr_h;
    logic [DimW-1:0]    spr_col;
    logic [DimW-1:0]    spr_row;
    logic               spr_masked;

    blit_write_t pending_writes[$];  // writes still owed by the DUT, oldest first
    dir_row_t    dir_rows[$];

    int n_sent     = 0;
    int n_writes   = 0;
    int n_errors   = 0;
    int n_settings = 0;
    bit tx_calm    = 1'b0;  // sender runs without gaps
    bit rx_calm    = 1'b0;  // receiver never stalls

    initial begin
        forever #6 aclk = ~aclk;
    end

    // Hard stop, far beyond the slowest correct run
    initial begin
        #(6_000_000);
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        if (n_errors < MaxPrinted)
            $display("[%0t] MISMATCH: %s", $time, msg);
        n_errors++;
    endtask

    task automatic reset_model();
        view_cfg.view_width    = VIEW_WIDTH_RST;
        view_cfg.view_height   = VIEW_HEIGHT_RST;
        view_cfg.line_pitch    = LINE_PITCH_RST;
        view_cfg.scroll_x      = '0;
        view_cfg.scroll_y      = '0;
        view_cfg.dest_base     = '0;
        view_cfg.honour_hidden = 1'b1;
        spr_org_x  = '0;
        spr_org_y  = '0;
        spr_w      = '0;
        spr_h      = '0;
        spr_col    = '0;
        spr_row    = '0;
        spr_masked = 1'b1;  // nothing is drawn until a header arrives
    endtask

    // Advance the sprite walker by one accepted transaction; return 1 when it draws
    function automatic bit predict_blit(input req_t r, output blit_write_t w);
        int px;
        int py;
        bit hit;
        hit = 1'b0;
        w   = '0;
        if (r.req_type == REQ_HEADER) begin
            // scroll and hiding are latched here, not per pixel
            spr_org_x  = 17'(int'($signed(r.sprite_x)) - int'($signed(view_cfg.scroll_x)));
            spr_org_y  = 17'(int'($signed(r.sprite_y)) - int'($signed(view_cfg.scroll_y)));
            spr_w      = r.frame_width;
            spr_h      = r.frame_height;
            spr_col    = '0;
            spr_row    = '0;
            spr_masked = (r.frame_width == 0) || (r.frame_height == 0) ||
                         (r.hidden && view_cfg.honour_hidden);
        end else if (!spr_masked) begin
            px = int'(spr_org_x) + int'(spr_col);
            py = int'(spr_org_y) + int'(spr_row);
            if (r.pixel != 0 && px >= 0 && py >= 0 &&
                px < int'(view_cfg.view_width) && py < int'(view_cfg.view_height)) begin
                hit     = 1'b1;
                w.addr  = view_cfg.dest_base + 32'(py) * 32'(view_cfg.line_pitch) + 32'(px);
                w.value = r.pixel;
            end
            // raster walk; the frame closes after its last pixel
            if (int'(spr_col) + 1 >= int'(spr_w)) begin
                spr_col = '0;
                if (int'(spr_row) + 1 >= int'(spr_h)) begin
                    spr_row    = '0;
                    spr_masked = 1'b1;
                end else begin
                    spr_row = spr_row + 1'b1;
                end
            end else begin
                spr_col = spr_col + 1'b1;
            end
        end
        return hit;
    endfunction

    // Write one register; the block is idle whenever this is called and the
    // caller drops the enable after its last write
    task automatic program_reg(input logic [CfgIndexW-1:0] idx, input logic [CfgDataW-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        case (idx)
            REG_VIEW_WIDTH:    view_cfg.view_width    = val[DimW-1:0];
            REG_VIEW_HEIGHT:   view_cfg.view_height   = val[DimW-1:0];
            REG_LINE_PITCH:    view_cfg.line_pitch    = val[PitchW-1:0];
            REG_SCROLL_X:      view_cfg.scroll_x      = val[CoordW-1:0];
            REG_SCROLL_Y:      view_cfg.scroll_y      = val[CoordW-1:0];
            REG_DEST_BASE:     view_cfg.dest_base     = val;
            REG_HONOUR_HIDDEN: view_cfg.honour_hidden = val[0];
            default: ;
        endcase
    endtask

    // Offer one transaction, hold it until the handshake, then log what it owes
    task automatic send_item(input req_t r, input exp_kind_t ek, input blit_write_t typed);
        int gap;
        bit hit;
        blit_write_t wr;
        gap = tx_calm ? 0 : int'($urandom_range(0, MaxIdle));
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= r.req_type;
        s_tdata  <= {7'b0, r.pixel, r.hidden, r.frame_height, r.frame_width,
                     r.sprite_y, r.sprite_x};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        // accepted at this edge
        hit = predict_blit(r, wr);
        n_sent++;
        case (ek)
            EXP_MODEL: if (hit) pending_writes.push_back(wr);
            EXP_WRITE: pending_writes.push_back(typed);
            default: ;
        endcase
    endtask

    // Drop the request stream, let every owed write land, then let the pipeline empty
    task automatic wait_for_quiet();
        int waited;
        s_tvalid <= 1'b0;
        waited = 0;
        while (pending_writes.size() != 0 && waited < DrainLimit) begin
            @(posedge aclk);
            waited++;
        end
        if (pending_writes.size() != 0) begin
            report_mismatch($sformatf("%0d expected writes never arrived, next addr %08h",
                                      pending_writes.size(), pending_writes[0].addr));
            pending_writes.delete();
        end
        repeat (SettleCyc) @(posedge aclk);
    endtask

    function automatic dir_row_t mk_hdr(input logic [15:0] x, input logic [15:0] y,
                                        input logic [11:0] w, input logic [11:0] h,
                                        input logic hid);
        dir_row_t d;
        d                  = '0;
        d.kind             = ROW_ITEM;
        d.ek               = EXP_NONE;  // a header never writes
        d.req.req_type     = REQ_HEADER;
        d.req.sprite_x     = x;
        d.req.sprite_y     = y;
        d.req.frame_width  = w;
        d.req.frame_height = h;
        d.req.hidden       = hid;
        return d;
    endfunction

    function automatic dir_row_t mk_pix(input logic [7:0] p, input exp_kind_t ek,
                                        input logic [31:0] a);
        dir_row_t d;
        d              = '0;
        d.kind         = ROW_ITEM;
        d.ek           = ek;
        d.req.req_type = REQ_PIXEL;
        d.req.pixel    = p;
        d.want.addr    = a;
        d.want.value   = p;
        return d;
    endfunction

    function automatic dir_row_t mk_reg(input logic [CfgIndexW-1:0] idx,
                                        input logic [CfgDataW-1:0] val);
        dir_row_t d;
        d         = '0;
        d.kind    = ROW_REG;
        d.ek      = EXP_NONE;
        d.reg_idx = idx;
        d.reg_val = val;
        return d;
    endfunction

    // Fully random transaction; every field bit toggles whatever the kind
    function automatic req_t rand_req();
        req_t r;
        r.req_type     = 1'($urandom);
        r.sprite_x     = 16'($urandom);
        r.sprite_y     = 16'($urandom);
        r.frame_width  = 12'($urandom);
        r.frame_height = 12'($urandom);
        r.hidden       = 1'($urandom);
        r.pixel        = 8'($urandom);
        return r;
    endfunction

    // Pixel transaction: roughly one in four transparent
    function automatic req_t rand_pix();
        req_t r;
        r          = rand_req();
        r.req_type = REQ_PIXEL;
        r.pixel    = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
        return r;
    endfunction

    // World coordinate near the view: on its near edge, its far edge or inside it
    function automatic logic [15:0] place_coord(input logic signed [15:0] scroll,
                                                input logic [11:0] span);
        int o;
        int s;
        case ($urandom_range(0, 2))
            0:       o = int'($urandom_range(0, 20)) - 12;
            1:       o = int'(span) - 6 + int'($urandom_range(0, 10));
            default: o = int'($urandom_range(0, int'(span)));
        endcase
        s = int'(scroll) + o;
        // keep the sum a legal 16-bit position so the origin stays near the view
        if (s > 32767)  s = 32767 - int'($urandom_range(0, 8));
        if (s < -32768) s = -32768;
        return 16'(s);
    endfunction

    // One random sequence: mostly complete sprites, some cut short, overrun or noise
    task automatic gen_sequence();
        int kind;
        int n;
        int w;
        int h;
        req_t hdr;
        kind = $urandom_range(0, 9);
        if (kind == 9) begin
            repeat ($urandom_range(1, 4)) send_item(rand_req(), EXP_MODEL, '0);
        end else begin
            hdr          = rand_req();
            hdr.req_type = REQ_HEADER;
            hdr.sprite_x = place_coord(view_cfg.scroll_x, view_cfg.view_width);
            hdr.sprite_y = place_coord(view_cfg.scroll_y, view_cfg.view_height);
            if (kind == 7) begin
                // broken sprite: arbitrary size, a few pixels, then the next header
                if ($urandom_range(0, 1) == 0) begin
                    hdr.frame_width  = 12'($urandom_range(1, 12));
                    hdr.frame_height = 12'($urandom_range(1, 6));
                end
                n = $urandom_range(0, 10);
            end else begin
                w = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
                h = $urandom_range(1, 6);
                hdr.frame_width  = 12'(w);
                hdr.frame_height = 12'(h);
                hdr.hidden       = ($urandom_range(0, 3) == 0);
                // a few sequences run past the end of the frame
                n = w * h + ((kind == 8) ? int'($urandom_range(1, 4)) : 0);
            end
            send_item(hdr, EXP_MODEL, '0);
            repeat (n) send_item(rand_pix(), EXP_MODEL, '0);
        end
    endtask

    // Register setting for a random phase: the two extremes first, then random
    task automatic pick_settings(input int ph);
        logic [31:0] vw;
        logic [31:0] vh;
        logic [31:0] pitch;
        logic [31:0] sx;
        logic [31:0] sy;
        logic [31:0] base;
        logic [31:0] hon;
        case (ph)
            0: begin
                vw = 1; vh = 1; pitch = 1;
                sx = 32'h0000_8000; sy = 32'h0000_8000;
                base = 32'h0; hon = 0;
            end
            1: begin
                vw = 4095; vh = 4095; pitch = 65535;
                sx = 32'h0000_7FFF; sy = 32'h0000_7FFF;
                base = 32'hFFFF_FFFF; hon = 1;
            end
            default: begin
                vw    = $urandom_range(0, 1) ? $urandom_range(1, 400) : $urandom_range(1, 4095);
                vh    = $urandom_range(0, 1) ? $urandom_range(1, 300) : $urandom_range(1, 4095);
                pitch = $urandom_range(0, 1) ? vw + $urandom_range(0, 64)
                                             : $urandom_range(1, 65535);
                sx    = $urandom;
                sy    = $urandom;
                base  = $urandom;
                hon   = $urandom_range(0, 1);
            end
        endcase
        program_reg(REG_VIEW_WIDTH, vw);
        program_reg(REG_VIEW_HEIGHT, vh);
        program_reg(REG_LINE_PITCH, pitch);
        program_reg(REG_SCROLL_X, sx);
        program_reg(REG_SCROLL_Y, sy);
        program_reg(REG_DEST_BASE, base);
        program_reg(REG_HONOUR_HIDDEN, hon);
        cfg_we <= 1'b0;
        n_settings++;
    endtask

    // Write receiver: draw a stall before each transaction, then take one
    initial begin : write_sink
        int stall;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = rx_calm ? 0 : int'($urandom_range(0, MaxIdle));
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    // Compare every accepted write with the oldest one owed
    always @(posedge aclk) begin : write_check
        blit_write_t want;
        if (aresetn && m_tvalid && m_tready) begin
            n_writes++;
            if (pending_writes.size() == 0) begin
                report_mismatch($sformatf("write with none owed: addr %08h value %02h",
                                          m_tdata[31:0], m_tdata[39:32]));
            end else begin
                want = pending_writes.pop_front();
                if (m_tdata[31:0] !== want.addr)
                    report_mismatch($sformatf("write_address %08h, owed %08h",
                                              m_tdata[31:0], want.addr));
                if (m_tdata[39:32] !== want.value)
                    report_mismatch($sformatf("write_value %02h at %08h, owed %02h",
                                              m_tdata[39:32], want.addr, want.value));
            end
        end
    end

    initial begin : stimulus
        int phase_end;
        reset_model();

        // Directed rows, all starting from the reset settings:
        // 320 x 200 view, pitch 320, base 0, no scroll, hidden sprites skipped.
        dir_rows.push_back(mk_pix(8'h11, EXP_NONE, 0));            // no header yet
        dir_rows.push_back(mk_hdr(16'd0, 16'd0, 12'd2, 12'd2, 1'b0));
        dir_rows.push_back(mk_pix(8'hFF, EXP_WRITE, 32'd0));
        dir_rows.push_back(mk_pix(8'h00, EXP_NONE, 0));            // transparent
        dir_rows.push_back(mk_pix(8'h01, EXP_WRITE, 32'd320));
        dir_rows.push_back(mk_pix(8'h80, EXP_WRITE, 32'd321));
        dir_rows.push_back(mk_pix(8'h42, EXP_NONE, 0));            // past the frame
        // bottom-right corner; the other three pixels fall outside the view
        dir_rows.push_back(mk_hdr(16'd319, 16'd199, 12'd2, 12'd2, 1'b0));
        dir_rows.push_back(mk_pix(8'h7E, EXP_WRITE, 32'd63999));
        dir_rows.push_back(mk_pix(8'h7E, EXP_NONE, 0));
        dir_rows.push_back(mk_pix(8'h7E, EXP_NONE, 0));
        dir_rows.push_back(mk_pix(8'h7E, EXP_NONE, 0));
        // straddle the top-left corner from negative coordinates
        dir_rows.push_back(mk_hdr(16'hFFFF, 16'hFFFF, 12'd2, 12'd2, 1'b0));
        dir_rows.push_back(mk_pix(8'h01, EXP_NONE, 0));
        dir_rows.push_back(mk_pix(8'h01, EXP_NONE, 0));
        dir_rows.push_back(mk_pix(8'h01, EXP_NONE, 0));
        dir_rows.push_back(mk_pix(8'h33, EXP_WRITE, 32'd0));
        // hidden sprite while hiding is honoured
        dir_rows.push_back(mk_hdr(16'd10, 16'd10, 12'd1, 12'd1, 1'b1));
        dir_rows.push_back(mk_pix(8'h55, EXP_NONE, 0));
        // zero frame width drops the pixels that follow
        dir_rows.push_back(mk_hdr(16'd5, 16'd5, 12'd0, 12'd3, 1'b0));
        dir_rows.push_back(mk_pix(8'h55, EXP_NONE, 0));
        // editor mode draws hidden sprites
        dir_rows.push_back(mk_reg(REG_HONOUR_HIDDEN, 32'd0));
        dir_rows.push_back(mk_hdr(16'd10, 16'd10, 12'd2, 12'd1, 1'b1));
        dir_rows.push_back(mk_pix(8'h55, EXP_WRITE, 32'd3210));
        // move the base mid-sprite: takes effect at once and wraps the address
        dir_rows.push_back(mk_reg(REG_DEST_BASE, 32'hFFFF_FFFF));
        dir_rows.push_back(mk_pix(8'hAA, EXP_WRITE, 32'd3210));
        // scroll of -5 shifts the next sprite five pixels right
        dir_rows.push_back(mk_reg(REG_SCROLL_X, 32'h0000_FFFB));
        dir_rows.push_back(mk_hdr(16'd0, 16'd0, 12'd1, 12'd1, 1'b0));
        dir_rows.push_back(mk_pix(8'h5A, EXP_WRITE, 32'd4));
        // extreme position and frame size
        dir_rows.push_back(mk_hdr(16'h7FFF, 16'h8000, 12'd4095, 12'd4095, 1'b0));
        dir_rows.push_back(mk_pix(8'hFF, EXP_MODEL, 0));
        dir_rows.push_back(mk_pix(8'h01, EXP_MODEL, 0));

        // hold reset, then release it for good
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_REG) begin
                wait_for_quiet();
                program_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
                cfg_we <= 1'b0;
            end else begin
                send_item(dir_rows[i].req, dir_rows[i].ek, dir_rows[i].want);
            end
        end
        wait_for_quiet();

        // Random part: one register setting per phase, idling varied per phase
        for (int ph = 0; ph < NumPhases; ph++) begin
            pick_settings(ph);
            tx_calm   = (ph == 2 || ph == 3) || ($urandom_range(0, 4) == 0);
            rx_calm   = (ph == 2 || ph == 4) || ($urandom_range(0, 4) == 0);
            phase_end = n_sent + PhaseItems;
            while (n_sent < phase_end) gen_sequence();
            wait_for_quiet();
        end

        $display("Sent %0d input transactions and checked %0d writes", n_sent, n_writes);
        $display("across %0d register settings plus the directed rows.", n_settings);
        if (n_errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
